[hw/rtl/sliding_window_mode_filter_top_assert.svh]
// Assertion macros shared by the mode filter RTL.
`ifndef SLIDING_WINDOW_MODE_FILTER_TOP_ASSERT_SVH
`define SLIDING_WINDOW_MODE_FILTER_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SWMF_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("swmf: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define SWMF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("swmf: next-cycle check failed");

`endif

[hw/rtl/swmf_pkg.sv]
package swmf_pkg;

   localparam int SAMPLE_W       = 16;
   localparam int THRESH_W       = 5;
   localparam int WINDOW_DEFAULT = 16;
   localparam int WINDOW_MAX     = 64;
   localparam int FILL_W_MAX     = $clog2(WINDOW_MAX + 1);
   localparam int QUEUE_DEPTH    = 2;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = THRESH_W;
   localparam logic [CSR_INDEX_W-1:0] CSR_STABLE_THRESHOLD = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SIGNED_ORDER     = 1'd1;

   localparam logic [THRESH_W-1:0] THRESH_RESET       = 5'd4;
   localparam logic                SIGNED_ORDER_RESET = 1'b1;

   // One accepted sample on its way from the front end to the mode engine.
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic [FILL_W_MAX-1:0]      fill;
      logic                       stable;
      logic                       signed_order;
   } swmf_job_type;

   typedef struct packed {
      logic                       stable;
      logic signed [SAMPLE_W-1:0] mode_value;
      logic signed [SAMPLE_W-1:0] last_value;
   } swmf_rsp_type;

   // Flipping the sign bit gives signed order under an unsigned compare.
   function automatic logic [SAMPLE_W-1:0] order_key(input logic [SAMPLE_W-1:0] v,
                                                     input logic sgn);
      return {v[SAMPLE_W-1] ^ sgn, v[SAMPLE_W-2:0]};
   endfunction

endpackage

[hw/rtl/swmf_front.sv]
module swmf_front #(
   parameter int WINDOW = swmf_pkg::WINDOW_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wen,
   input  logic [swmf_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [swmf_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic                                 req_push,
   input  logic signed [swmf_pkg::SAMPLE_W-1:0] req_sample,
   output logic                                 req_full,
   input  logic                                 q_full,
   output logic                                 q_push,
   output swmf_pkg::swmf_job_type               q_job
);
   import swmf_pkg::*;

   localparam int FILL_W = $clog2(WINDOW + 1);
   localparam int CMP_W  = (FILL_W > THRESH_W) ? FILL_W : THRESH_W;

   logic [THRESH_W-1:0] thresh_ff, thresh_in;
   logic                sgn_ff, sgn_in;
   logic [FILL_W-1:0]   fill_ff, fill_in;
   logic [FILL_W-1:0]   fill_next;
   logic                accept;

   assign req_full = q_full;
   assign accept   = req_push && !q_full;
   assign q_push   = accept;

   // Count saturates once the window is full.
   assign fill_next = (fill_ff == FILL_W'(WINDOW)) ? fill_ff : fill_ff + 1'b1;

   always_comb begin
      q_job.sample       = req_sample;
      q_job.fill         = FILL_W_MAX'(fill_next);
      q_job.stable       = CMP_W'(fill_next) > CMP_W'(thresh_ff);
      q_job.signed_order = sgn_ff;
   end

   always_comb begin
      thresh_in = thresh_ff;
      sgn_in    = sgn_ff;
      if (csr_wen) begin
         unique case (csr_index)
            CSR_STABLE_THRESHOLD: thresh_in = csr_wdata[THRESH_W-1:0];
            CSR_SIGNED_ORDER:     sgn_in    = csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign fill_in = accept ? fill_next : fill_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= THRESH_RESET;
         sgn_ff    <= SIGNED_ORDER_RESET;
         fill_ff   <= '0;
      end else begin
         thresh_ff <= thresh_in;
         sgn_ff    <= sgn_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

[hw/rtl/swmf_queue.sv]
module swmf_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  swmf_pkg::swmf_job_type push_data,
   output logic                   full,
   input  logic                   pop,
   output logic                   empty,
   output swmf_pkg::swmf_job_type pop_data
);
   `include "sliding_window_mode_filter_top_assert.svh"
   import swmf_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   swmf_job_type     mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full     = (cnt_ff == CNT_W'(QUEUE_DEPTH));
   assign empty    = (cnt_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   `SWMF_ASSERT_IMPLY(a_queue_count_range, clock, reset, 1'b1, cnt_ff <= CNT_W'(QUEUE_DEPTH))

endmodule

[hw/rtl/swmf_back.sv]
module swmf_back #(
   parameter int WINDOW = swmf_pkg::WINDOW_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_empty,
   input  swmf_pkg::swmf_job_type q_job,
   output logic                   q_pop,
   input  logic                   rsp_pop,
   output logic                   rsp_empty,
   output swmf_pkg::swmf_rsp_type rsp_data
);
   `include "sliding_window_mode_filter_top_assert.svh"
   import swmf_pkg::*;

   localparam int FILL_W = $clog2(WINDOW + 1);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_RUN    = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [SAMPLE_W-1:0] win_ff [WINDOW];
   logic [SAMPLE_W-1:0] win_in [WINDOW];
   logic [SAMPLE_W-1:0] rot_ff [WINDOW];
   logic [SAMPLE_W-1:0] rot_in [WINDOW];
   swmf_job_type        job_ff, job_in;
   logic [FILL_W-1:0]   step_ff, step_in;
   logic                s1_vld_ff, s1_vld_in;
   logic [WINDOW-1:0]   s1_match_ff, s1_match_in;
   logic [SAMPLE_W-1:0] s1_cand_ff, s1_cand_in;
   logic                s2_vld_ff, s2_vld_in;
   logic [FILL_W-1:0]   s2_cnt_ff, s2_cnt_in;
   logic [SAMPLE_W-1:0] s2_cand_ff, s2_cand_in;
   logic [FILL_W-1:0]   best_cnt_ff, best_cnt_in;
   logic [SAMPLE_W-1:0] best_ff, best_in;
   logic                out_vld_ff, out_vld_in;
   swmf_rsp_type        out_ff, out_in;
   logic [FILL_W-1:0]   fill;
   logic                issue;
   logic                better;
   logic                out_free;
   logic                load_out;

   assign fill      = job_ff.fill[FILL_W-1:0];
   assign issue     = (state_ff == ST_RUN) && (step_ff < fill);
   assign out_free  = !out_vld_ff || rsp_pop;
   assign load_out  = (state_ff == ST_FINISH) && out_free;
   assign rsp_empty = !out_vld_ff;
   assign rsp_data  = out_ff;
   assign q_pop     = (state_ff == ST_IDLE) && !q_empty;

   // Stage 1: compare the candidate against every valid window entry.
   always_comb begin
      s1_vld_in  = issue;
      s1_cand_in = rot_ff[0];
      for (int j = 0; j < WINDOW; j++) begin
         s1_match_in[j] = (win_ff[j] == rot_ff[0]) && (FILL_W'(j) < fill);
      end
   end

   // Stage 2: count matches.
   assign s2_vld_in  = s1_vld_ff;
   assign s2_cnt_in  = FILL_W'($countones(s1_match_ff));
   assign s2_cand_in = s1_cand_ff;

   // Stage 3: keep the most frequent, smallest key on a tie of two or more.
   assign better = (s2_cnt_ff > best_cnt_ff) ||
                   ((s2_cnt_ff == best_cnt_ff) && (best_cnt_ff >= FILL_W'(2)) &&
                    (order_key(s2_cand_ff, job_ff.signed_order) <
                     order_key(best_ff, job_ff.signed_order)));

   always_comb begin
      state_in    = state_ff;
      win_in      = win_ff;
      rot_in      = rot_ff;
      job_in      = job_ff;
      step_in     = step_ff;
      best_cnt_in = best_cnt_ff;
      best_in     = best_ff;
      out_in      = out_ff;
      out_vld_in  = out_vld_ff && !rsp_pop;

      if (s2_vld_ff && better) begin
         best_cnt_in = s2_cnt_ff;
         best_in     = s2_cand_ff;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               // Newest sample enters at the head; the oldest drops off the tail.
               win_in[0] = q_job.sample;
               for (int j = 1; j < WINDOW; j++) begin
                  win_in[j] = win_ff[j-1];
               end
               rot_in      = win_in;
               job_in      = q_job;
               step_in     = '0;
               best_cnt_in = FILL_W'(1);
               best_in     = '0;
               state_in    = ST_RUN;
            end
         end
         ST_RUN: begin
            if (issue) begin
               for (int j = 0; j < WINDOW - 1; j++) begin
                  rot_in[j] = rot_ff[j+1];
               end
               rot_in[WINDOW-1] = rot_ff[0];
               step_in = step_ff + 1'b1;
            end else if (!s1_vld_ff && !s2_vld_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               out_in.stable     = job_ff.stable;
               out_in.mode_value = best_ff;
               out_in.last_value = job_ff.sample;
               out_vld_in        = 1'b1;
               state_in          = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         s1_vld_ff  <= s1_vld_in;
         s2_vld_ff  <= s2_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff      <= win_in;
      rot_ff      <= rot_in;
      job_ff      <= job_in;
      step_ff     <= step_in;
      s1_match_ff <= s1_match_in;
      s1_cand_ff  <= s1_cand_in;
      s2_cnt_ff   <= s2_cnt_in;
      s2_cand_ff  <= s2_cand_in;
      best_cnt_ff <= best_cnt_in;
      best_ff     <= best_in;
      out_ff      <= out_in;
   end

   `SWMF_ASSERT_IMPLY(a_candidate_self_match, clock, reset, s2_vld_ff, s2_cnt_ff != '0)
   `SWMF_ASSERT_IMPLY(a_step_bound, clock, reset, state_ff == ST_RUN, step_ff <= fill)
   `SWMF_ASSERT_NEXT(a_finish_loads_output, clock, reset, load_out, out_vld_ff)

endmodule

[hw/rtl/sliding_window_mode_filter_top.sv]
// Channel   Direction  Handshake              Payload
// req       in         req_push / req_full    req_sample
// rsp       out        rsp_pop / rsp_empty    rsp_stable, rsp_mode_value, rsp_last_value
// csr       in         csr_wen                csr_index, csr_wdata
//
// The front end takes a sample and queues it (two entries deep).
// The mode engine works on one sample at a time, with a scan
// that tests one window entry as candidate per cycle.
// reset is synchronous: the fill count clears, registers return to threshold 4, signed order.
// req_full rises only when the queue is full; a waiting result stalls the engine only at its end.
module sliding_window_mode_filter_top #(
   parameter int WINDOW = swmf_pkg::WINDOW_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_push,
   output logic                                 req_full,
   input  logic signed [swmf_pkg::SAMPLE_W-1:0] req_sample,
   output logic                                 rsp_empty,
   input  logic                                 rsp_pop,
   output logic                                 rsp_stable,
   output logic signed [swmf_pkg::SAMPLE_W-1:0] rsp_mode_value,
   output logic signed [swmf_pkg::SAMPLE_W-1:0] rsp_last_value,
   input  logic                                 csr_wen,
   input  logic [swmf_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [swmf_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import swmf_pkg::*;

   swmf_job_type push_job;
   swmf_job_type pop_job;
   swmf_rsp_type rsp;
   logic         q_push;
   logic         q_full;
   logic         q_pop;
   logic         q_empty;

   swmf_front #(.WINDOW(WINDOW)) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_push   (req_push),
      .req_sample (req_sample),
      .req_full   (req_full),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_job      (push_job)
   );

   swmf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_job),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .pop_data  (pop_job)
   );

   swmf_back #(.WINDOW(WINDOW)) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_job     (pop_job),
      .q_pop     (q_pop),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp)
   );

   assign rsp_stable     = rsp.stable;
   assign rsp_mode_value = rsp.mode_value;
   assign rsp_last_value = rsp.last_value;

endmodule
